[hdl/sbf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence body formatter package
// Shared constants, character codes and the command record that travels
// from the front end to the back end through the command queue.
// ----------------------------------------------------------------------------
package sbf_pkg;

  // Default parameter values.
  localparam int DEF_LINE_RESIDUES  = 50;
  localparam int DEF_GROUP_RESIDUES = 10;
  localparam int DEF_NUMBER_DIGITS  = 8;
  localparam int DEF_QUEUE_DEPTH    = 4;

  // The position is held as eight BCD digits.
  localparam int BCD_DIGITS = 8;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int SIG_W      = 4;

  // Character codes.
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // One classified request for the back end.
  typedef struct packed {
    logic               flush;       // end of sequence with a partial line
    logic [7:0]         residue;     // residue character
    logic               line_start;  // print the position first
    logic               group_end;   // group space after the residue
    logic               line_end;    // two newlines after the residue
    logic [BCD_W-1:0]   bcd;         // position digits
    logic [SIG_W-1:0]   sig;         // number of significant digits
  } cmd_t;

endpackage : sbf_pkg
`default_nettype wire

[hdl/sbf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence body formatter front end
// Accepts input requests, drops gap characters, tracks the residue position,
// the line phase and the group fill, and writes one command per request
// that produces text.
// ----------------------------------------------------------------------------
module sbf_front
  import sbf_pkg::*;
#(
  parameter int LINE_RESIDUES  = DEF_LINE_RESIDUES,
  parameter int GROUP_RESIDUES = DEF_GROUP_RESIDUES,
  parameter int NUMBER_DIGITS  = DEF_NUMBER_DIGITS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic [7:0] seq_byte,
  input  wire logic       end_marker,
  input  wire logic       q_full,
  output logic            q_wr,
  output cmd_t            q_cmd
);

  localparam int LM_W       = $clog2(LINE_RESIDUES);
  localparam int GF_W       = $clog2(GROUP_RESIDUES + 1);
  localparam int LIM_DIGITS = (NUMBER_DIGITS < BCD_DIGITS) ? NUMBER_DIGITS : BCD_DIGITS;

  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [LM_W-1:0]  line_mod_r, line_mod_nxt;
  logic [GF_W-1:0]  group_fill_r, group_fill_nxt;

  logic             accept;
  logic             is_gap;
  logic             residue;
  logic             line_start;
  logic             line_end;
  logic             group_end;
  logic [GF_W-1:0]  group_inc;
  logic             at_limit;
  logic [BCD_W-1:0] bcd_inc;
  logic [SIG_W-1:0] sig;

  assign accept     = push && !q_full;
  assign is_gap     = (seq_byte == CH_DOT) || (seq_byte == CH_DASH) || (seq_byte == CH_TILDE);
  assign residue    = !end_marker && !is_gap;
  assign line_start = (line_mod_r == LM_W'(1));
  assign line_end   = (line_mod_r == '0);
  assign group_inc  = group_fill_r + GF_W'(1);
  assign group_end  = (group_inc == GF_W'(GROUP_RESIDUES));

  // Saturation test, BCD increment and count of significant digits.
  always_comb begin
    logic       carry;
    logic [3:0] d;
    at_limit = 1'b1;
    carry    = 1'b1;
    bcd_inc  = bcd_r;
    sig      = SIG_W'(1);
    for (int i = 0; i < BCD_DIGITS; i++) begin
      d = bcd_r[4*i +: 4];
      if (i < LIM_DIGITS && d != 4'd9) begin
        at_limit = 1'b0;
      end
      if (carry) begin
        if (d == 4'd9) begin
          bcd_inc[4*i +: 4] = 4'd0;
        end else begin
          bcd_inc[4*i +: 4] = d + 4'd1;
          carry = 1'b0;
        end
      end
      if (d != 4'd0) begin
        sig = SIG_W'(i + 1);
      end
    end
  end

  // Next state of the position, line phase and group fill.
  always_comb begin
    bcd_nxt        = bcd_r;
    line_mod_nxt   = line_mod_r;
    group_fill_nxt = group_fill_r;
    if (accept) begin
      if (end_marker) begin
        bcd_nxt        = BCD_W'(1);
        line_mod_nxt   = LM_W'(1);
        group_fill_nxt = '0;
      end else if (residue) begin
        group_fill_nxt = group_end ? '0 : group_inc;
        if (!at_limit) begin
          bcd_nxt      = bcd_inc;
          line_mod_nxt = (line_mod_r == LM_W'(LINE_RESIDUES - 1)) ? '0
                                                                  : line_mod_r + LM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcd_r        <= BCD_W'(1);
      line_mod_r   <= LM_W'(1);
      group_fill_r <= '0;
    end else begin
      bcd_r        <= bcd_nxt;
      line_mod_r   <= line_mod_nxt;
      group_fill_r <= group_fill_nxt;
    end
  end

  // Command toward the back end; nothing for gaps or a flush at a line start.
  assign q_wr = accept && (residue || (end_marker && !line_start));

  always_comb begin
    q_cmd            = '0;
    q_cmd.flush      = end_marker;
    q_cmd.residue    = seq_byte;
    q_cmd.line_start = line_start;
    q_cmd.group_end  = group_end;
    q_cmd.line_end   = line_end;
    q_cmd.bcd        = bcd_r;
    q_cmd.sig        = sig;
  end

endmodule : sbf_front
`default_nettype wire

[hdl/sbf_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence body formatter command queue
// Short first-in first-out store of commands between front and back end.
// ----------------------------------------------------------------------------
module sbf_queue
  import sbf_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr,
  input  cmd_t      wr_cmd,
  output logic      full,
  input  wire logic rd,
  output cmd_t      rd_cmd,
  output logic      valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full   = (count_r == CNT_W'(DEPTH));
  assign valid  = (count_r != '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && valid;
  assign rd_cmd = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule : sbf_queue
`default_nettype wire

[hdl/sbf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence body formatter back end
// Expands one command at a time into text bytes, one byte per cycle, and
// holds the current byte on the result ports until it is taken.
// ----------------------------------------------------------------------------
module sbf_back
  import sbf_pkg::*;
#(
  parameter int NUMBER_DIGITS = DEF_NUMBER_DIGITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  cmd_t      q_cmd,
  input  wire logic q_valid,
  output logic      q_rd,
  output logic      empty,
  input  wire logic pop,
  output logic [7:0] out_byte,
  output logic       run_last
);

  localparam int CNT_W = $clog2(NUMBER_DIGITS);

  typedef enum logic [6:0] {
    PH_NUM = 7'b0000001,  // position digits
    PH_SPC = 7'b0000010,  // two spaces after the position
    PH_RES = 7'b0000100,  // residue character
    PH_GRP = 7'b0001000,  // group space
    PH_NL  = 7'b0010000,  // two newlines at line end
    PH_FSP = 7'b0100000,  // flush space
    PH_FNL = 7'b1000000   // flush newline
  } phase_t;

  logic             busy_r, busy_nxt;
  cmd_t             cmd_r;
  phase_t           phase_r, phase_nxt, phase_adv, phase_first;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_adv, cnt_first;
  logic             last;
  logic             take;
  logic             load;
  logic [SIG_W-1:0] place;
  logic [3:0]       digit;

  assign empty    = !busy_r;
  assign run_last = last;
  assign take     = busy_r && pop;
  assign load     = q_valid && (!busy_r || (take && last));
  assign q_rd     = load;
  assign place    = SIG_W'(cnt_r);

  // Digit at the current place; places beyond the BCD word read as zero.
  always_comb begin
    digit = 4'd0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (place == SIG_W'(i)) begin
        digit = cmd_r.bcd[4*i +: 4];
      end
    end
  end

  // Byte shown for the current phase.
  always_comb begin
    unique case (phase_r) inside
      PH_NUM:  out_byte = (place < cmd_r.sig) ? (CH_ZERO + {4'd0, digit}) : CH_SPACE;
      PH_RES:  out_byte = cmd_r.residue;
      PH_NL,
      PH_FNL:  out_byte = CH_NL;
      default: out_byte = CH_SPACE;
    endcase
  end

  // Step to the next byte of the command, and mark the final byte.
  always_comb begin
    phase_adv = phase_r;
    cnt_adv   = cnt_r;
    last      = 1'b0;
    unique case (phase_r)
      PH_NUM: begin
        if (cnt_r == '0) begin
          phase_adv = PH_SPC;
          cnt_adv   = CNT_W'(1);
        end else begin
          cnt_adv = cnt_r - CNT_W'(1);
        end
      end
      PH_SPC: begin
        if (cnt_r == '0) begin
          phase_adv = PH_RES;
        end else begin
          cnt_adv = cnt_r - CNT_W'(1);
        end
      end
      PH_RES: begin
        if (cmd_r.group_end) begin
          phase_adv = PH_GRP;
        end else if (cmd_r.line_end) begin
          phase_adv = PH_NL;
          cnt_adv   = CNT_W'(1);
        end else begin
          last = 1'b1;
        end
      end
      PH_GRP: begin
        if (cmd_r.line_end) begin
          phase_adv = PH_NL;
          cnt_adv   = CNT_W'(1);
        end else begin
          last = 1'b1;
        end
      end
      PH_NL: begin
        if (cnt_r == '0) begin
          last = 1'b1;
        end else begin
          cnt_adv = cnt_r - CNT_W'(1);
        end
      end
      PH_FSP: begin
        phase_adv = PH_FNL;
      end
      PH_FNL: begin
        last = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  // First byte of a newly loaded command.
  always_comb begin
    cnt_first = CNT_W'(NUMBER_DIGITS - 1);
    if (q_cmd.flush) begin
      phase_first = PH_FSP;
    end else if (q_cmd.line_start) begin
      phase_first = PH_NUM;
    end else begin
      phase_first = PH_RES;
    end
  end

  // Control update.
  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      busy_nxt  = 1'b1;
      phase_nxt = phase_first;
      cnt_nxt   = cnt_first;
    end else if (take) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        phase_nxt = phase_adv;
        cnt_nxt   = cnt_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_RES;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Command payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= q_cmd;
    end
  end

endmodule : sbf_back
`default_nettype wire

[hdl/gcg_sequence_body_formatter_unit.sv]
`default_nettype none
// A request accepted while the back end is idle is written into a queue slot and then
// loaded into the back end's command register, from which its first text byte shows.
// Throughput: one input request per cycle into the command queue while it is not
// full, and one text byte per cycle out while pop is high; the back end's single
// byte per cycle sets the sustained rate. Reset: synchronous, active low; clears the
// position to 1, the group fill, the command queue and the back end. No clearing pass.
// ----------------------------------------------------------------------------
// Sequence body formatter top level
// Front end classifies sequence bytes, a short queue decouples it from the
// back end that writes the formatted text one byte per cycle while pop is high.
// ----------------------------------------------------------------------------
module gcg_sequence_body_formatter_unit
  import sbf_pkg::*;
#(
  parameter int LINE_RESIDUES  = DEF_LINE_RESIDUES,
  parameter int GROUP_RESIDUES = DEF_GROUP_RESIDUES,
  parameter int NUMBER_DIGITS  = DEF_NUMBER_DIGITS,
  parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_seq_byte,
  input  wire logic       in_end_marker,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_run_last
);

  logic q_wr, q_full, q_rd, q_valid;
  cmd_t q_wr_cmd, q_rd_cmd;

  assign full = q_full;

  // Front end: classification and position tracking.
  sbf_front #(
    .LINE_RESIDUES (LINE_RESIDUES),
    .GROUP_RESIDUES(GROUP_RESIDUES),
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .seq_byte  (in_seq_byte),
    .end_marker(in_end_marker),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_cmd     (q_wr_cmd)
  );

  // Command queue between the two halves.
  sbf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wr_cmd(q_wr_cmd),
    .full  (q_full),
    .rd    (q_rd),
    .rd_cmd(q_rd_cmd),
    .valid (q_valid)
  );

  // Back end: text generation.
  sbf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (q_rd_cmd),
    .q_valid (q_valid),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .out_byte(out_byte),
    .run_last(out_run_last)
  );

endmodule : gcg_sequence_body_formatter_unit
`default_nettype wire

[hdl/sbf_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence body formatter port checker
// Watches the top level's ports for reset behavior, stable stalled results
// and the relation between a full input side and the result side.
// ----------------------------------------------------------------------------
module sbf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       out_run_last
);

  // After reset nothing waits on the result side.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  // After reset the input side takes requests.
  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_run_last)))
    else $error("stalled result changed");

  // The command queue only fills up while the back end has a result waiting.
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !empty)
    else $error("input side full with no result waiting");

endmodule : sbf_checker

bind gcg_sequence_body_formatter_unit sbf_checker u_sbf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_byte    (out_byte),
  .out_run_last(out_run_last)
);
`default_nettype wire
